### rtl/s2i_pkg.sv
// ----------------------------------------------------------------------------
// s2i_pkg
// Types and constants shared by the string to int64 parser modules.
// ----------------------------------------------------------------------------
package s2i_pkg;

    localparam int CH_W     = 8;
    localparam int BASE_W   = 6;
    localparam int DIGIT_W  = 6;
    localparam int VALUE_W  = 64;
    localparam int OFFS_W   = 16;
    localparam int ADDR_W   = 3;
    localparam int APB_W    = 32;

    // radix codes
    localparam logic [BASE_W-1:0] BASE_DETECT = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN    = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX    = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET  = 6'd10;

    localparam logic [VALUE_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_MAX = 64'h8000_0000_0000_0000;

    // character codes
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] UPPER_OFS = 8'd55;  // 'A' - 10
    localparam logic [CH_W-1:0] LOWER_OFS = 8'd87;  // 'a' - 10

    // register index taken from paddr[2]
    localparam logic REG_NUMBER_BASE = 1'b0;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b000_0001,
        PH_SKIP     = 7'b000_0010,
        PH_SIGNED   = 7'b000_0100,
        PH_ZERO     = 7'b000_1000,
        PH_HEXSTART = 7'b001_0000,
        PH_DIGITS   = 7'b010_0000,
        PH_DONE     = 7'b100_0000
    } t_phase;

    typedef struct packed {
        logic               is_space;
        logic               is_plus;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               dig_valid;
        logic [DIGIT_W-1:0] dig;
    } t_char_class;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ovf;
        logic               digits;
        logic [OFFS_W-1:0]  end_offset;
    } t_result;

endpackage

### rtl/s2i_char_class.sv
// ----------------------------------------------------------------------------
// s2i_char_class
// Decodes one character into whitespace, sign, prefix and digit value.
// ----------------------------------------------------------------------------
module s2i_char_class (
    input  logic [s2i_pkg::CH_W-1:0] i_ch,
    output s2i_pkg::t_char_class     o_class
);

    logic [s2i_pkg::CH_W-1:0] dig_full;

    always_comb begin
        dig_full = '0;
        o_class  = '0;
        o_class.is_space = (i_ch == s2i_pkg::CH_SPACE) ||
                           (i_ch inside {[s2i_pkg::CH_TAB:s2i_pkg::CH_CR]});
        o_class.is_plus  = (i_ch == s2i_pkg::CH_PLUS);
        o_class.is_minus = (i_ch == s2i_pkg::CH_MINUS);
        o_class.is_zero  = (i_ch == s2i_pkg::CH_0);
        o_class.is_x     = (i_ch == s2i_pkg::CH_LX) || (i_ch == s2i_pkg::CH_UX);
        if (i_ch inside {[s2i_pkg::CH_0:s2i_pkg::CH_9]}) begin
            dig_full          = i_ch - s2i_pkg::CH_0;
            o_class.dig_valid = 1'b1;
        end else if (i_ch inside {[s2i_pkg::CH_UA:s2i_pkg::CH_UZ]}) begin
            dig_full          = i_ch - s2i_pkg::UPPER_OFS;
            o_class.dig_valid = 1'b1;
        end else if (i_ch inside {[s2i_pkg::CH_LA:s2i_pkg::CH_LZ]}) begin
            dig_full          = i_ch - s2i_pkg::LOWER_OFS;
            o_class.dig_valid = 1'b1;
        end
        o_class.dig = dig_full[s2i_pkg::DIGIT_W-1:0];
    end

endmodule

### rtl/s2i_core.sv
// ----------------------------------------------------------------------------
// s2i_core
// Parse state, accumulator multiply-add and result formation for one char.
// ----------------------------------------------------------------------------
module s2i_core #(
    parameter longint unsigned OFFSET_LIMIT = 65535
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [s2i_pkg::CH_W-1:0]   i_ch,
    input  logic                       i_first,
    input  logic [s2i_pkg::BASE_W-1:0] i_number_base,
    output logic                       o_result_valid,
    output s2i_pkg::t_result           o_result
);

    localparam int POS_W = $clog2(OFFSET_LIMIT + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(OFFSET_LIMIT);
    localparam int PROD_W = s2i_pkg::VALUE_W + s2i_pkg::BASE_W;

    s2i_pkg::t_char_class cls;

    s2i_pkg::t_phase              r_phase, n_phase, ph;
    logic                         r_neg, n_neg;
    logic [s2i_pkg::VALUE_W-1:0]  r_acc, n_acc;
    logic                         r_ovf, n_ovf;
    logic                         r_any, n_any;
    logic [s2i_pkg::BASE_W-1:0]   r_eb, n_eb;
    logic [POS_W-1:0]             r_pos, n_pos;

    logic                         active;
    logic                         start;
    logic                         run;
    logic                         digit_ok;
    logic [PROD_W-1:0]            prod;
    logic [s2i_pkg::VALUE_W-1:0]  limit;
    logic [POS_W+s2i_pkg::OFFS_W-1:0] pos_ext;

    s2i_char_class u_char_class (
        .i_ch    (i_ch),
        .o_class (cls)
    );

    always_comb begin
        active = i_first || !((r_phase == s2i_pkg::PH_IDLE) ||
                              (r_phase == s2i_pkg::PH_DONE));
        ph     = i_first ? s2i_pkg::PH_SKIP : r_phase;
        n_phase = ph;
        n_neg   = i_first ? 1'b0 : r_neg;
        n_acc   = i_first ? '0 : r_acc;
        n_ovf   = i_first ? 1'b0 : r_ovf;
        n_any   = i_first ? 1'b0 : r_any;
        n_eb    = i_first ? i_number_base : r_eb;
        n_pos   = r_pos;
        if (i_first) begin
            n_pos = '0;
        end else if (active && (r_pos < POS_LIMIT)) begin
            n_pos = r_pos + 1'b1;
        end

        start    = 1'b0;
        run      = 1'b0;
        digit_ok = 1'b0;
        prod     = '0;
        o_result_valid = 1'b0;

        case (ph)
            s2i_pkg::PH_SKIP: begin
                if (cls.is_space) begin
                    n_phase = s2i_pkg::PH_SKIP;
                end else if (cls.is_plus || cls.is_minus) begin
                    n_neg   = cls.is_minus;
                    n_phase = s2i_pkg::PH_SIGNED;
                end else begin
                    start = 1'b1;
                end
            end
            s2i_pkg::PH_SIGNED: begin
                start = 1'b1;
            end
            s2i_pkg::PH_ZERO: begin
                if (cls.is_x) begin
                    n_eb    = s2i_pkg::BASE_HEX;
                    n_phase = s2i_pkg::PH_HEXSTART;
                end else begin
                    // leading zero counts as a digit; accumulator stays zero
                    if (n_eb == s2i_pkg::BASE_DETECT) begin
                        n_eb = s2i_pkg::BASE_OCT;
                    end
                    n_any = 1'b1;
                    run   = 1'b1;
                end
            end
            s2i_pkg::PH_HEXSTART, s2i_pkg::PH_DIGITS: begin
                run = 1'b1;
            end
            default: begin
                n_phase = ph;
            end
        endcase

        if (start) begin
            if (((n_eb == s2i_pkg::BASE_DETECT) || (n_eb == s2i_pkg::BASE_HEX)) &&
                cls.is_zero) begin
                n_phase = s2i_pkg::PH_ZERO;
            end else begin
                if (n_eb == s2i_pkg::BASE_DETECT) begin
                    n_eb = s2i_pkg::BASE_DEC;
                end
                run = 1'b1;
            end
        end

        limit = n_neg ? s2i_pkg::NEG_MAX : s2i_pkg::POS_MAX;

        if (run) begin
            digit_ok = cls.dig_valid && (n_eb >= s2i_pkg::BASE_MIN) &&
                       (n_eb <= s2i_pkg::BASE_MAX) && (cls.dig < n_eb);
            if (digit_ok) begin
                prod = {{s2i_pkg::BASE_W{1'b0}}, n_acc} * n_eb +
                       {{s2i_pkg::VALUE_W{1'b0}}, cls.dig};
                if (n_ovf || (prod > {{s2i_pkg::BASE_W{1'b0}}, limit})) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = prod[s2i_pkg::VALUE_W-1:0];
                end
                n_any   = 1'b1;
                n_phase = s2i_pkg::PH_DIGITS;
            end else begin
                o_result_valid = active;
                n_phase        = s2i_pkg::PH_DONE;
            end
        end

        pos_ext = (POS_W + s2i_pkg::OFFS_W)'(n_pos);
        o_result.ovf        = n_any && n_ovf;
        o_result.digits     = n_any;
        o_result.end_offset = n_any ? pos_ext[s2i_pkg::OFFS_W-1:0] : '0;
        if (!n_any) begin
            o_result.value = '0;
        end else if (n_ovf) begin
            o_result.value = limit;
        end else begin
            o_result.value = n_neg ? (~n_acc + 1'b1) : n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= s2i_pkg::PH_IDLE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_any   <= 1'b0;
            r_eb    <= s2i_pkg::BASE_RESET;
            r_pos   <= '0;
        end else if (i_fire && active) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_any   <= n_any;
            r_eb    <= n_eb;
            r_pos   <= n_pos;
        end
    end

endmodule

### rtl/string_to_int64_parser.sv
// ----------------------------------------------------------------------------
// string_to_int64_parser
// Streaming strtoll-style parser: one character per transaction in, one
// signed 64-bit result per terminated string out.
// ----------------------------------------------------------------------------
// Path: input register, combinational core, then the result register.
// Throughput: one character per cycle unless the sink stalls; the state
// update (6-bit by 64-bit multiply-add, overflow compare) closes in the
// single core stage. Stall: input holds while the result waits on the sink.
// Reset: synchronous, active low; parser idles until a start flag, base = 10.
// ----------------------------------------------------------------------------
module string_to_int64_parser #(
    parameter longint unsigned OFFSET_LIMIT = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic [0:0]  s_axis_tuser,   // [0] first
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [63:0] value, [79:64] end_offset
    output logic [1:0]  m_axis_tuser,   // [0] overflow, [1] digits_seen
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [s2i_pkg::ADDR_W-1:0] paddr,
    input  logic [s2i_pkg::APB_W-1:0]  pwdata,
    output logic [s2i_pkg::APB_W-1:0]  prdata,
    output logic                       pready
);

    logic                         r_in_valid;
    logic [s2i_pkg::CH_W-1:0]     r_in_ch;
    logic                         r_in_first;
    logic                         r_out_valid;
    s2i_pkg::t_result             r_out;
    logic [s2i_pkg::BASE_W-1:0]   r_base;

    logic                         fire;
    logic                         core_valid;
    s2i_pkg::t_result             core_result;
    logic                         cfg_wr;

    // advance the core when a character is held and the result register can take its output
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    s2i_core #(
        .OFFSET_LIMIT (OFFSET_LIMIT)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_ch           (r_in_ch),
        .i_first        (r_in_first),
        .i_number_base  (r_base),
        .o_result_valid (core_valid),
        .o_result       (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ch    <= s_axis_tdata;
            r_in_first <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= core_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_valid) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.end_offset, r_out.value};
    assign m_axis_tuser  = {r_out.digits, r_out.ovf};

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == s2i_pkg::REG_NUMBER_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= s2i_pkg::BASE_RESET;
        end else if (cfg_wr) begin
            r_base <= pwdata[s2i_pkg::BASE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == s2i_pkg::REG_NUMBER_BASE) begin
            prdata = s2i_pkg::APB_W'(r_base);
        end
    end

    // ------------------------------------------------------------------------
    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_no_digit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.digits) |->
        ((r_out.value == '0) && (r_out.end_offset == '0) && !r_out.ovf))
        else $error("result without digits carries nonzero fields");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && core_valid) |=> m_axis_tvalid)
        else $error("core result not presented");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_base == $past(pwdata[s2i_pkg::BASE_W-1:0])))
        else $error("number base write lost");

endmodule
